[design/sas_pkg.sv]
// shared types, constants and helpers of the sprite animation sequencer
// no dependencies; every other file of the block imports this package

package sas_pkg;

  localparam int TIME_BITS_DEF = 24;
  localparam int GRID_MAX      = 64;

  localparam int CMD_W    = 3;
  localparam int DT_W     = 24;
  localparam int PERIOD_W = 24;
  localparam int FRAME_W  = 12;
  localparam int GRID_W   = 7;
  localparam int TILE_W   = 6;

  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESUME = 3'd4;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_SPR    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROWS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOOP   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_MOD,
    S_UPD,
    S_DLD,
    S_DIV,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic [GRID_W-1:0]   sprites_per_row;
    logic [GRID_W-1:0]   sheet_rows;
    logic [FRAME_W-1:0]  start_frame;
    logic [FRAME_W-1:0]  end_frame;
    logic                loop_enable;
    logic [PERIOD_W-1:0] frame_period;
  } cfg_regs_t;

  typedef struct packed {
    logic               set_frame;
    logic [FRAME_W-1:0] frame;
  } cfg_evt_t;

  typedef struct packed {
    logic load;
    logic add_en;
    logic mod_en;
  } acc_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // zero counts as one, counts above the grid limit saturate
  function automatic logic [GRID_W-1:0] grid_clamp(input logic [GRID_W-1:0] v);
    logic [GRID_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = GRID_W'(1);
    end else if (int'(v) > GRID_MAX) begin
      r = GRID_W'(GRID_MAX);
    end
    return r;
  endfunction

endpackage

[design/sas_if.sv]
// valid/ready channel interfaces for command items and result items
// depends on sas_pkg for field widths

interface sas_in_if import sas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [DT_W-1:0]    delta_time;

  modport source (output valid, output cmd, output delta_time, input ready);
  modport sink   (input valid, input cmd, input delta_time, output ready);
endinterface

interface sas_out_if import sas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] shown_frame;
  logic [TILE_W-1:0]  tile_column;
  logic [TILE_W-1:0]  tile_row;
  logic               is_playing;
  logic               is_paused;

  modport source (output valid, output shown_frame, output tile_column, output tile_row,
                  output is_playing, output is_paused, input ready);
  modport sink   (input valid, input shown_frame, input tile_column, input tile_row,
                  input is_playing, input is_paused, output ready);
endinterface

[design/sprite_animation_sequencer_unit.sv]
// sprite animation sequencer, top level: control sequencer, playback state,
// result register; uses sas_pkg, sas_if, sas_cfg_regs, sas_acc_unit, sas_tile_div
//
// One command item is taken at a time. A tick that finds the animation playing
// and not paused runs the accumulator bit-serially: a serial add of the elapsed
// time, then a serial remainder by the frame period. Every other command skips
// the accumulator. Both paths end in a serial divide that turns the shown frame
// into tile column and row. The next command is accepted while a result still
// waits in the output register; only a second result waits for it to drain.
// Configuration goes through the APB-style port, register i at byte address
// 4*i, and is to be written only while the block is idle; the block itself
// does not enforce this. No clearing pass after reset.

module sprite_animation_sequencer_unit import sas_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  sas_in_if.sink            in_ch,
  sas_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int ACC_W = TIME_BITS + 1;
  localparam int MAXN  = (ACC_W > FRAME_W) ? ACC_W : FRAME_W;
  localparam int CNT_W = $clog2(MAXN);
  localparam int TOT_W = 2 * GRID_W;

  // configuration
  cfg_regs_t cfg;
  cfg_evt_t  cfg_evt;

  // sequencer
  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_inc;
  logic             cnt_last;
  acc_ctl_t         acc_ctl;
  div_ctl_t         div_ctl;
  logic             in_ready;
  logic             in_acc;
  logic             upd_en;
  logic             out_load;

  // latched command
  logic [CMD_W-1:0] cmd_r;
  logic             run_r;
  logic             run_now;

  // playback state
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [FRAME_W-1:0] cf_r, cf_nxt;
  logic [FRAME_W-1:0] disp_r, disp_nxt;
  logic               play_r, play_nxt;
  logic               pause_r, pause_nxt;

  // datapath results
  logic [ACC_W-1:0]   acc_rem;
  logic               acc_adv;
  logic [TILE_W-1:0]  div_col;
  logic [TILE_W-1:0]  div_row;

  // grid and clamping
  logic [GRID_W-1:0]  ccols;
  logic [GRID_W-1:0]  crows;
  logic [TOT_W-1:0]   total;
  logic [TOT_W-1:0]   total_m1;
  logic [FRAME_W-1:0] start_cl;
  logic [FRAME_W-1:0] end_cl;
  logic [FRAME_W-1:0] step_frame;
  logic [FRAME_W-1:0] step_cl;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0] o_frame_r;
  logic [TILE_W-1:0]  o_col_r;
  logic [TILE_W-1:0]  o_row_r;
  logic               o_play_r;
  logic               o_pause_r;

  // a frame beyond the last tile is held at the last tile
  function automatic logic [FRAME_W-1:0] clamp_frame(input logic [FRAME_W-1:0] id,
                                                      input logic [TOT_W-1:0]   lim);
    logic [FRAME_W-1:0] r;
    r = id;
    if (TOT_W'(id) > lim) begin
      r = lim[FRAME_W-1:0];
    end
    return r;
  endfunction

  sas_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .evt     (cfg_evt)
  );

  sas_acc_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_acc (
    .clk      (clk),
    .ctl      (acc_ctl),
    .acc_i    (acc_r),
    .dt_i     (in_ch.delta_time),
    .period_i (cfg.frame_period),
    .rem_o    (acc_rem),
    .adv_o    (acc_adv)
  );

  sas_tile_div u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .frame_i  (disp_r),
    .cols_i   (ccols),
    .column_o (div_col),
    .row_o    (div_row)
  );

  // grid size and clamped range ends
  assign ccols    = grid_clamp(cfg.sprites_per_row);
  assign crows    = grid_clamp(cfg.sheet_rows);
  assign total    = TOT_W'(ccols) * TOT_W'(crows);
  assign total_m1 = total - TOT_W'(1);
  assign start_cl = clamp_frame(cfg.start_frame, total_m1);
  assign end_cl   = clamp_frame(cfg.end_frame, total_m1);

  // next frame on an advance: past the end wraps to the start
  assign step_frame = (cf_r >= cfg.end_frame) ? cfg.start_frame : cf_r + FRAME_W'(1);
  assign step_cl    = clamp_frame(step_frame, total_m1);

  assign in_acc  = in_ch.valid && in_ready;
  assign run_now = (in_ch.cmd == CMD_TICK) && play_r && !pause_r;

  // the divide phase runs one step per frame bit, the accumulator phases one per time bit
  assign cnt_last = (state_r == S_DIV) ? (cnt_r == CNT_W'(FRAME_W - 1))
                                       : (cnt_r == CNT_W'(ACC_W - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = run_now ? S_ADD : S_UPD;
        end
      end
      S_ADD: begin
        if (cnt_last) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (cnt_last) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: state_nxt = S_DLD;
      S_DLD: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready       = 1'b0;
    acc_ctl.load   = 1'b0;
    acc_ctl.add_en = 1'b0;
    acc_ctl.mod_en = 1'b0;
    div_ctl.load   = 1'b0;
    div_ctl.step   = 1'b0;
    cnt_inc        = 1'b0;
    upd_en         = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        acc_ctl.load = in_ch.valid;
      end
      S_ADD: begin
        acc_ctl.add_en = 1'b1;
        cnt_inc        = 1'b1;
      end
      S_MOD: begin
        acc_ctl.mod_en = 1'b1;
        cnt_inc        = 1'b1;
      end
      S_UPD: upd_en       = 1'b1;
      S_DLD: div_ctl.load = 1'b1;
      S_DIV: begin
        div_ctl.step = 1'b1;
        cnt_inc      = 1'b1;
      end
      S_OUT: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign cnt_nxt = (cnt_inc && !cnt_last) ? cnt_r + CNT_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_ch.cmd;
      run_r <= run_now;
    end
  end

  // playback state update, once per item, and a frame counter restart on a range write
  always_comb begin
    acc_nxt   = acc_r;
    cf_nxt    = cf_r;
    disp_nxt  = disp_r;
    play_nxt  = play_r;
    pause_nxt = pause_r;
    if (cfg_evt.set_frame) begin
      // moving the range restarts the frame counter at the start
      cf_nxt = cfg_evt.frame;
    end else if (upd_en) begin
      case (cmd_r)
        CMD_TICK: begin
          if (run_r) begin
            acc_nxt = acc_rem;
            if (acc_adv) begin
              cf_nxt   = step_cl;
              disp_nxt = step_cl;
            end
            // without looping, reaching the end frame stops playback
            if (!cfg.loop_enable && ((acc_adv ? step_cl : cf_r) == cfg.end_frame)) begin
              play_nxt  = 1'b0;
              pause_nxt = 1'b0;
              cf_nxt    = end_cl;
              disp_nxt  = end_cl;
            end
          end
        end
        CMD_PLAY: begin
          play_nxt  = 1'b1;
          pause_nxt = 1'b0;
          acc_nxt   = '0;
          cf_nxt    = start_cl;
          disp_nxt  = start_cl;
        end
        CMD_STOP: begin
          play_nxt  = 1'b0;
          pause_nxt = 1'b0;
          cf_nxt    = end_cl;
          disp_nxt  = end_cl;
        end
        CMD_PAUSE:  pause_nxt = 1'b1;
        CMD_RESUME: begin
          pause_nxt = 1'b0;
          acc_nxt   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cf_r    <= '0;
      disp_r  <= '0;
      play_r  <= 1'b0;
      pause_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      cf_r    <= cf_nxt;
      disp_r  <= disp_nxt;
      play_r  <= play_nxt;
      pause_r <= pause_nxt;
    end
  end

  // result register, frees the sequencer from the consumer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_frame_r <= disp_r;
      o_col_r   <= div_col;
      o_row_r   <= div_row;
      o_play_r  <= play_r;
      o_pause_r <= pause_r;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.shown_frame = o_frame_r;
  assign out_ch.tile_column = o_col_r;
  assign out_ch.tile_row    = o_row_r;
  assign out_ch.is_playing  = o_play_r;
  assign out_ch.is_paused   = o_pause_r;

endmodule

[design/sas_cfg_regs.sv]
// apb-style configuration registers of the sprite animation sequencer
// depends on sas_pkg for register layout and indexes

module sas_cfg_regs import sas_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         cfg,
  output cfg_evt_t          evt
);

  cfg_regs_t            regs_r;
  cfg_regs_t            regs_nxt;
  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[APB_AW-1:2];
  assign cfg    = regs_r;

  always_comb begin
    regs_nxt      = regs_r;
    evt.set_frame = 1'b0;
    evt.frame     = regs_r.start_frame;
    if (wr) begin
      case (idx)
        REG_SPR:    regs_nxt.sprites_per_row = pwdata[GRID_W-1:0];
        REG_ROWS:   regs_nxt.sheet_rows      = pwdata[GRID_W-1:0];
        REG_START: begin
          regs_nxt.start_frame = pwdata[FRAME_W-1:0];
          evt.set_frame        = 1'b1;
          evt.frame            = pwdata[FRAME_W-1:0];
        end
        REG_END: begin
          regs_nxt.end_frame = pwdata[FRAME_W-1:0];
          evt.set_frame      = 1'b1;
        end
        REG_LOOP:   regs_nxt.loop_enable  = pwdata[0];
        REG_PERIOD: regs_nxt.frame_period = pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.sprites_per_row <= GRID_W'(1);
      regs_r.sheet_rows      <= GRID_W'(1);
      regs_r.start_frame     <= '0;
      regs_r.end_frame       <= '0;
      regs_r.loop_enable     <= 1'b0;
      regs_r.frame_period    <= PERIOD_W'(1);
    end else begin
      regs_r <= regs_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_SPR:    prdata = APB_DW'(regs_r.sprites_per_row);
      REG_ROWS:   prdata = APB_DW'(regs_r.sheet_rows);
      REG_START:  prdata = APB_DW'(regs_r.start_frame);
      REG_END:    prdata = APB_DW'(regs_r.end_frame);
      REG_LOOP:   prdata = APB_DW'(regs_r.loop_enable);
      REG_PERIOD: prdata = APB_DW'(regs_r.frame_period);
      default:    prdata = '0;
    endcase
  end

endmodule

[design/sas_acc_unit.sv]
// bit-serial time accumulator: serial add of the elapsed time, then
// a restoring remainder by the frame period, one bit per cycle; uses sas_pkg

module sas_acc_unit import sas_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                clk,
  input  acc_ctl_t            ctl,
  input  logic [TIME_BITS:0]  acc_i,
  input  logic [DT_W-1:0]     dt_i,
  input  logic [PERIOD_W-1:0] period_i,
  output logic [TIME_BITS:0]  rem_o,
  output logic                adv_o
);

  localparam int W = TIME_BITS + 1;

  logic [W-1:0] dt_m;
  logic [W-1:0] per_m;
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic         c_r, c_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic         qany_r, qany_nxt;
  logic         sum_bit;
  logic [W-1:0] trial;
  logic [W-1:0] diff;
  logic         ge;

  // both operands are cut to the time width, a zero period acts as one
  always_comb begin
    dt_m  = '0;
    per_m = '0;
    for (int i = 0; i < W; i++) begin
      if (i < TIME_BITS && i < DT_W) begin
        dt_m[i] = dt_i[i];
      end
      if (i < TIME_BITS && i < PERIOD_W) begin
        per_m[i] = period_i[i];
      end
    end
    if (per_m == '0) begin
      per_m = W'(1);
    end
  end

  assign sum_bit = a_r[0] ^ b_r[0] ^ c_r;
  assign trial   = {rem_r[W-2:0], a_r[W-1]};
  assign ge      = (trial >= per_m);
  assign diff    = trial - per_m;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    c_nxt    = c_r;
    rem_nxt  = rem_r;
    qany_nxt = qany_r;
    if (ctl.load) begin
      a_nxt    = acc_i;
      b_nxt    = dt_m;
      c_nxt    = 1'b0;
      rem_nxt  = '0;
      qany_nxt = 1'b0;
    end else if (ctl.add_en) begin
      // sum bits enter at the top, lsb first
      a_nxt = {sum_bit, a_r[W-1:1]};
      b_nxt = {1'b0, b_r[W-1:1]};
      c_nxt = (a_r[0] & b_r[0]) | (c_r & (a_r[0] ^ b_r[0]));
    end else if (ctl.mod_en) begin
      // dividend leaves msb first into the partial remainder
      a_nxt = {a_r[W-2:0], 1'b0};
      if (ge) begin
        rem_nxt  = diff;
        qany_nxt = 1'b1;
      end else begin
        rem_nxt = trial;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    rem_r  <= rem_nxt;
    qany_r <= qany_nxt;
  end

  assign rem_o = rem_r;
  assign adv_o = qany_r;

endmodule

[design/sas_tile_div.sv]
// bit-serial restoring divider of the shown frame by the column count,
// one quotient bit per cycle; uses sas_pkg

module sas_tile_div import sas_pkg::*; (
  input  logic               clk,
  input  div_ctl_t           ctl,
  input  logic [FRAME_W-1:0] frame_i,
  input  logic [GRID_W-1:0]  cols_i,
  output logic [TILE_W-1:0]  column_o,
  output logic [TILE_W-1:0]  row_o
);

  logic [FRAME_W-1:0] q_r, q_nxt;
  logic [GRID_W-1:0]  d_r, d_nxt;
  logic [GRID_W-1:0]  rem_r, rem_nxt;
  logic [GRID_W:0]    trial;
  logic [GRID_W:0]    diff;
  logic               ge;

  assign trial = {rem_r, q_r[FRAME_W-1]};
  assign ge    = (trial >= {1'b0, d_r});
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    q_nxt   = q_r;
    d_nxt   = d_r;
    rem_nxt = rem_r;
    if (ctl.load) begin
      q_nxt   = frame_i;
      d_nxt   = cols_i;
      rem_nxt = '0;
    end else if (ctl.step) begin
      q_nxt   = {q_r[FRAME_W-2:0], ge};
      rem_nxt = ge ? diff[GRID_W-1:0] : trial[GRID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  // both results are reported modulo 64
  assign column_o = rem_r[TILE_W-1:0];
  assign row_o    = q_r[TILE_W-1:0];

endmodule

[design/sas_checker.sv]
// port-level checks of the sprite animation sequencer and their bind
// depends on sas_pkg and on the top level sprite_animation_sequencer_unit

module sas_checker import sas_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FRAME_W-1:0] shown_frame,
  input logic [TILE_W-1:0]  tile_column,
  input logic [TILE_W-1:0]  tile_row,
  input logic               is_playing,
  input logic               is_paused
);

  // a result offered and not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(shown_frame) && $stable(tile_column)
      && $stable(tile_row) && $stable(is_playing) && $stable(is_paused))
    else $error("stalled result item changed");

  // one item at a time: an accepted command closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  // a fresh result only comes out of a busy sequencer
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result item appeared without work in flight");

endmodule

bind sprite_animation_sequencer_unit sas_checker u_sas_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .shown_frame (out_ch.shown_frame),
  .tile_column (out_ch.tile_column),
  .tile_row    (out_ch.tile_row),
  .is_playing  (out_ch.is_playing),
  .is_paused   (out_ch.is_paused)
);
